// ===== rtl/core/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Mapped region table package
// Shared constants, request codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int ADDR_BITS_DEF  = 38;
    localparam logic [37:0] CEILING_RESET = 38'd274877898752;

    localparam logic [2:0] REQ_MAP   = 3'd0;
    localparam logic [2:0] REQ_UNMAP = 3'd1;
    localparam logic [2:0] REQ_FAULT = 3'd2;
    localparam logic [2:0] REQ_QUERY = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [3:0] CAUSE_EXEC  = 4'd12;
    localparam logic [3:0] CAUSE_LOAD  = 4'd13;
    localparam logic [3:0] CAUSE_STORE = 4'd15;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request, start a scan
        logic scan;      // examine the slot under the scan pointer
        logic restart;   // restart the scan pointer at slot zero
        logic commit;    // apply the table update and form the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last; // the scan pointer is on the last slot
        logic hit;       // the map search found an overlap this pass
        logic done;      // the request is fully resolved
    } t_stat;

endpackage

// ===== rtl/core/mrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mapped region table controller
// Sequences request capture, slot scans, rescans and commit, and owns the
// output handshake.
// ----------------------------------------------------------------------------
module mrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output mrt_pkg::t_cmd o_cmd,
    input  mrt_pkg::t_stat i_stat
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT, ST_OUT} t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;

    // Command decode from the present state.
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = i_valid && o_ready;
        o_cmd.scan    = (r_state == ST_SCAN);
        o_cmd.restart = (r_state == ST_SCAN) && i_stat.scan_last && i_stat.hit
                        && !i_stat.done;
        o_cmd.commit  = (r_state == ST_COMMIT);
    end

    // State and the registered output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (r_out_valid && i_ready) r_out_valid <= 1'b0;
                    if (i_valid && o_ready) r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (i_stat.done || (i_stat.scan_last && !i_stat.hit))
                        r_state <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    property p_no_load_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.load |-> !r_out_valid;
    endproperty
    a_no_load_busy: assert property (p_no_load_busy) else $error("load while output held");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid) else $error("commit without result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid) else $error("result dropped");

endmodule

// ===== rtl/core/mrt_dp.sv =====
// ----------------------------------------------------------------------------
// Mapped region table datapath
// Holds the region table and request registers, examines one slot per cycle
// under controller command and forms the result.
// ----------------------------------------------------------------------------
module mrt_dp #(
    parameter int SLOTS      = mrt_pkg::SLOTS_DEF,
    parameter int PAGE_BYTES = mrt_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = mrt_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    input  mrt_pkg::t_cmd        i_cmd,
    output mrt_pkg::t_stat       o_stat,
    input  logic [2:0]           i_req_type,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [ADDR_BITS-1:0] i_length,
    input  logic [31:0]          i_file_offset,
    input  logic [2:0]           i_prot,
    input  logic                 i_shared,
    input  logic [7:0]           i_file_id,
    input  logic [ADDR_BITS-1:0] i_heap_top,
    input  logic [3:0]           i_cause,
    output logic                 o_status,
    output logic [ADDR_BITS-1:0] o_result_addr,
    output logic [3:0]           o_slot,
    output logic [4:0]           o_pte_perm,
    output logic [7:0]           o_region_file,
    output logic [31:0]          o_read_offset,
    output logic [12:0]          o_read_length,
    output logic                 o_region_freed
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PB = $clog2(PAGE_BYTES);
    localparam int AW = ADDR_BITS;
    localparam int PW = SLOTS + 2; // pass counter range, SLOTS+1 passes

    // Region table with per-slot registers; length zero marks an empty slot.
    logic [AW-1:0] r_start   [SLOTS];
    logic [AW-1:0] r_len     [SLOTS];
    logic [AW-1:0] r_flen    [SLOTS];
    logic [31:0]   r_foff    [SLOTS];
    logic [2:0]    r_prot_t  [SLOTS];
    logic          r_shared_t[SLOTS];
    logic [7:0]    r_fh      [SLOTS];

    logic [AW-1:0] r_ceiling;

    // Request registers; the rounded length and floor keep their carry bit.
    logic [2:0]    r_type;
    logic [AW-1:0] r_addr, r_req_len;
    logic [AW:0]   r_len_up, r_floor;
    logic [31:0]   r_foff_in;
    logic [2:0]    r_prot_in;
    logic          r_shared_in;
    logic [7:0]    r_fid_in;
    logic [3:0]    r_cause;

    // Scan registers.
    logic [SW-1:0] r_ptr;
    logic [$clog2(PW+1)-1:0] r_pass;
    logic [AW-1:0] r_end;
    logic          r_hit;
    logic          r_free_ok;
    logic [SW-1:0] r_free;
    logic          r_found;
    logic [SW-1:0] r_fslot;
    logic [AW-1:0] r_min;
    logic          r_done;
    logic          r_fail;

    // Page rounding of the captured length and heap top.
    logic [AW:0] len_up_w, heap_up_w;
    assign len_up_w  = ({1'b0, i_length} + (AW+1)'(PAGE_BYTES-1)) >> PB << PB;
    assign heap_up_w = ({1'b0, i_heap_top} + (AW+1)'(PAGE_BYTES-1)) >> PB << PB;

    // Slot under the scan pointer.
    logic [AW-1:0] s_start, s_len;
    logic [AW:0]   s_rend;
    logic          s_used;
    assign s_start = r_start[r_ptr];
    assign s_len   = r_len[r_ptr];
    assign s_used  = (s_len != '0);
    assign s_rend  = {1'b0, s_start} + {1'b0, s_len};

    // Candidate start for the map search and the fault page.
    logic [AW-1:0] cand, page_a, probe;
    assign cand   = r_end - r_len_up[AW-1:0];
    assign page_a = {r_addr[AW-1:PB], PB'(0)};
    assign probe  = (r_type == mrt_pkg::REQ_FAULT) ? page_a : r_addr;

    logic s_contains, s_overlap;
    assign s_contains = s_used && (probe >= s_start) && ({1'b0, probe} < s_rend);
    assign s_overlap  = s_used && ({1'b0, cand} < s_rend) && (r_end > s_start);

    logic map_bad;
    assign map_bad = ({1'b0, r_end} < r_len_up) || ({1'b0, cand} < r_floor);

    logic ptr_last;
    assign ptr_last = (r_ptr == SW'(SLOTS-1));

    always_comb begin
        o_stat           = '0;
        o_stat.scan_last = ptr_last;
        o_stat.hit       = r_hit || (r_type == mrt_pkg::REQ_MAP && s_overlap && !r_done);
        o_stat.done      = r_done;
    end

    // Scan sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.load) begin
            r_type      <= i_req_type;
            r_addr      <= i_addr;
            r_req_len   <= i_length;
            r_len_up    <= len_up_w;
            r_floor     <= heap_up_w;
            r_foff_in   <= i_file_offset;
            r_prot_in   <= i_prot;
            r_shared_in <= i_shared;
            r_fid_in    <= i_file_id;
            r_cause     <= i_cause;
            r_ptr       <= '0;
            r_pass      <= '0;
            r_end       <= r_ceiling;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_free      <= '0;
            r_found     <= 1'b0;
            r_fslot     <= '0;
            r_min       <= r_ceiling;
            r_fail      <= 1'b0;
            // Map fails at once on a zero or oversized length.
            r_done      <= (i_req_type == mrt_pkg::REQ_MAP) &&
                           ((i_length == '0) || len_up_w[AW] ||
                            (len_up_w[AW-1:0] > r_ceiling));
            if ((i_req_type == mrt_pkg::REQ_MAP) &&
                ((i_length == '0) || len_up_w[AW] || (len_up_w[AW-1:0] > r_ceiling)))
                r_fail <= 1'b1;
        end else if (i_cmd.scan && !r_done) begin
            r_ptr <= ptr_last ? '0 : r_ptr + SW'(1);
            if (!s_used && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_ptr;
            end
            if (s_contains && !r_found) begin
                r_found <= 1'b1;
                r_fslot <= r_ptr;
            end
            if (s_used && s_start < r_min) r_min <= s_start;
            if (r_type == mrt_pkg::REQ_MAP) begin
                if (map_bad) begin
                    r_done <= 1'b1;
                    r_fail <= 1'b1;
                end else if (s_overlap && !r_hit) begin
                    r_hit <= 1'b1;
                    r_end <= s_start;
                end
                if (i_cmd.restart) begin
                    r_hit  <= 1'b0;
                    r_pass <= r_pass + $bits(r_pass)'(1);
                    if (int'(r_pass) >= SLOTS) begin
                        r_done <= 1'b1;
                        r_fail <= 1'b1;
                    end
                end
            end
        end
    end

    // Result and table update, applied in the commit cycle.
    logic [AW-1:0] u_end, u_rend, f_delta, f_rl;
    logic [SW-1:0] fs;
    logic [2:0]    f_p;
    logic          f_ok;
    logic [4:0]    f_perm;
    assign fs      = r_fslot;
    assign u_end   = r_addr + r_len_up[AW-1:0];
    assign u_rend  = r_start[fs] + r_len[fs];
    assign f_p     = r_prot_t[fs];
    assign f_delta = page_a - r_start[fs];
    assign f_rl    = r_flen[fs] - f_delta;
    assign f_ok    = !((r_cause == mrt_pkg::CAUSE_LOAD  && !f_p[0]) ||
                       (r_cause == mrt_pkg::CAUSE_STORE && !f_p[1]) ||
                       (r_cause == mrt_pkg::CAUSE_EXEC  && !f_p[2]));
    assign f_perm  = 5'd16 | ((f_p[0] | f_p[1]) ? 5'd2 : 5'd0) |
                     (f_p[1] ? 5'd4 : 5'd0) | (f_p[2] ? 5'd8 : 5'd0);

    logic u_ok;
    assign u_ok = (r_req_len != '0) && (r_addr[PB-1:0] == '0) && r_found &&
                  ({1'b0, r_addr} + r_len_up <= {1'b0, u_rend}) &&
                  !((r_addr != r_start[fs]) && (u_end != u_rend));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= mrt_pkg::CEILING_RESET[AW-1:0];
            for (int i = 0; i < SLOTS; i++) begin
                r_len[i] <= '0; r_start[i] <= '0; r_flen[i] <= '0; r_foff[i] <= '0;
                r_prot_t[i] <= '0; r_shared_t[i] <= 1'b0; r_fh[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_ceiling <= i_cfg_data;
            if (i_cmd.commit) begin
                o_status <= 1'b1; o_result_addr <= '0; o_slot <= '0; o_pte_perm <= '0;
                o_region_file <= '0; o_read_offset <= '0; o_read_length <= '0;
                o_region_freed <= 1'b0;
                case (r_type)
                    mrt_pkg::REQ_MAP: begin
                        if (!r_fail && r_free_ok) begin
                            r_start[r_free] <= cand;  r_len[r_free] <= r_len_up[AW-1:0];
                            r_flen[r_free] <= r_req_len; r_foff[r_free] <= r_foff_in;
                            r_prot_t[r_free] <= r_prot_in;
                            r_shared_t[r_free] <= r_shared_in;
                            r_fh[r_free] <= r_fid_in;
                            o_status <= 1'b0; o_result_addr <= cand;
                            o_slot <= 4'(r_free);
                        end
                    end
                    mrt_pkg::REQ_UNMAP: begin
                        if (u_ok) begin
                            o_status <= 1'b0; o_slot <= 4'(fs); o_region_file <= r_fh[fs];
                            if (r_addr == r_start[fs] && u_end == u_rend) begin
                                r_start[fs] <= '0; r_len[fs] <= '0; r_flen[fs] <= '0;
                                r_foff[fs] <= '0; r_prot_t[fs] <= '0;
                                r_shared_t[fs] <= 1'b0; r_fh[fs] <= '0;
                                o_region_freed <= 1'b1;
                            end else if (r_addr == r_start[fs]) begin
                                r_start[fs] <= u_end;
                                r_foff[fs]  <= r_foff[fs] + r_len_up[31:0];
                                r_len[fs]   <= r_len[fs] - r_len_up[AW-1:0];
                                r_flen[fs]  <= (r_flen[fs] > r_len_up[AW-1:0]) ?
                                               r_flen[fs] - r_len_up[AW-1:0] : '0;
                            end else begin
                                r_len[fs] <= r_len[fs] - r_len_up[AW-1:0];
                                if (r_flen[fs] > r_len[fs] - r_len_up[AW-1:0])
                                    r_flen[fs] <= r_len[fs] - r_len_up[AW-1:0];
                            end
                        end
                    end
                    mrt_pkg::REQ_FAULT: begin
                        if (r_found && f_ok) begin
                            o_status <= 1'b0; o_slot <= 4'(fs); o_pte_perm <= f_perm;
                            o_region_file <= r_fh[fs];
                            o_read_offset <= r_foff[fs] + f_delta[31:0];
                            if (f_delta < r_flen[fs])
                                o_read_length <= (f_rl > AW'(PAGE_BYTES)) ?
                                    13'(PAGE_BYTES) : 13'(f_rl);
                        end
                    end
                    mrt_pkg::REQ_QUERY: begin
                        o_status <= 1'b0; o_result_addr <= r_min;
                    end
                    mrt_pkg::REQ_CLEAR: begin
                        o_status <= 1'b0;
                        for (int i = 0; i < SLOTS; i++) begin
                            r_len[i] <= '0; r_start[i] <= '0; r_flen[i] <= '0;
                            r_foff[i] <= '0; r_prot_t[i] <= '0;
                            r_shared_t[i] <= 1'b0; r_fh[i] <= '0;
                        end
                    end
                    default: o_status <= 1'b1;
                endcase
            end
        end
    end

    a_restart_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restart |-> r_type == mrt_pkg::REQ_MAP) else $error("rescan outside map");

    a_restart_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restart |=> r_ptr == '0) else $error("rescan not at slot zero");

    a_load_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_ptr == '0 && r_pass == '0)) else $error("scan not reset");

endmodule

// ===== rtl/core/mapped_region_table.sv =====
// ----------------------------------------------------------------------------
// Mapped region table
// Fixed table of mapped regions serving map, unmap, fault, query and clear.
// ----------------------------------------------------------------------------
// Flow: each request is captured, scanned over the slots and committed; a map
// request rescans for up to SLOTS + 1 passes, one slot examined per cycle.
// Throughput: one request at a time; the next is taken once the result is gone.
// Reset: synchronous, clears the table and loads the default ceiling at once.
module mapped_region_table #(
    parameter int SLOTS      = mrt_pkg::SLOTS_DEF,
    parameter int PAGE_BYTES = mrt_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = mrt_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_req_type,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [ADDR_BITS-1:0] i_length,
    input  logic [31:0]          i_file_offset,
    input  logic [2:0]           i_prot,
    input  logic                 i_shared,
    input  logic [7:0]           i_file_id,
    input  logic [ADDR_BITS-1:0] i_heap_top,
    input  logic [3:0]           i_cause,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_status,
    output logic [ADDR_BITS-1:0] o_result_addr,
    output logic [3:0]           o_slot,
    output logic [4:0]           o_pte_perm,
    output logic [7:0]           o_region_file,
    output logic [31:0]          o_read_offset,
    output logic [12:0]          o_read_length,
    output logic                 o_region_freed
);

    mrt_pkg::t_cmd  cmd;
    mrt_pkg::t_stat stat;

    // Sequencing of each request.
    mrt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(cmd), .i_stat(stat)
    );

    // Table and request arithmetic.
    mrt_dp #(.SLOTS(SLOTS), .PAGE_BYTES(PAGE_BYTES), .ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_cmd(cmd), .o_stat(stat),
        .i_req_type, .i_addr, .i_length, .i_file_offset, .i_prot, .i_shared,
        .i_file_id, .i_heap_top, .i_cause, .o_status, .o_result_addr, .o_slot,
        .o_pte_perm, .o_region_file, .o_read_offset, .o_read_length, .o_region_freed
    );

endmodule

// ===== dv/mapped_region_table_checker.sv =====
// ----------------------------------------------------------------------------
// Mapped region table checker
// Watches the request and result channels, keeps its own copy of the region
// table, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mapped_region_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [37:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_req_type,
    input  logic [37:0] i_addr,
    input  logic [37:0] i_length,
    input  logic [31:0] i_file_offset,
    input  logic [2:0]  i_prot,
    input  logic        i_shared,
    input  logic [7:0]  i_file_id,
    input  logic [37:0] i_heap_top,
    input  logic [3:0]  i_cause,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic        i_status,
    input  logic [37:0] i_result_addr,
    input  logic [3:0]  i_slot,
    input  logic [4:0]  i_pte_perm,
    input  logic [7:0]  i_region_file,
    input  logic [31:0] i_read_offset,
    input  logic [12:0] i_read_length,
    input  logic        i_region_freed,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    localparam int NSLOT = 16;
    localparam logic [38:0] PAGE = 39'd4096;

    typedef struct packed {
        logic        status;
        logic [37:0] addr;
        logic [3:0]  slot;
        logic [4:0]  perm;
        logic [7:0]  file;
        logic [31:0] roff;
        logic [12:0] rlen;
        logic        freed;
    } t_outcome;

    // Model copy of the table; 39-bit sums avoid wrap in comparisons.
    logic [37:0] ceiling;
    logic [37:0] rstart [NSLOT];
    logic [37:0] rlength [NSLOT];
    logic [37:0] rflen [NSLOT];
    logic [31:0] rfoff [NSLOT];
    logic [2:0]  rprot [NSLOT];
    logic        rshared [NSLOT];
    logic [7:0]  rfile [NSLOT];

    t_outcome expected_results[$];

    function automatic logic [38:0] round_to_page(logic [38:0] x);
        return ((x + PAGE - 1) / PAGE) * PAGE;
    endfunction

    function automatic int region_holding(logic [38:0] a);
        for (int i = 0; i < NSLOT; i++)
            if (rlength[i] != 0 && a >= rstart[i] && a < rstart[i] + 39'(rlength[i]))
                return i;
        return -1;
    endfunction

    task automatic drop_slot(int i);
        rstart[i] = '0; rlength[i] = '0; rflen[i] = '0; rfoff[i] = '0;
        rprot[i] = '0; rshared[i] = 1'b0; rfile[i] = '0;
    endtask

    task automatic predict_request(output t_outcome r);
        logic ok;
        logic [38:0] len, fin, start, floor_a, a, rend, page, delta, rl;
        logic [4:0] perm;
        int s, hitslot;
        r = '0;
        ok = 1'b0;
        case (i_req_type)
            mrt_pkg::REQ_MAP: begin
                len = round_to_page(39'(i_length));
                s = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (rlength[i] == 0) s = i;
                if (i_length != 0 && s >= 0 && len <= 39'(ceiling)) begin
                    floor_a = round_to_page(39'(i_heap_top));
                    fin = 39'(ceiling);
                    for (int pass = 0; pass <= NSLOT; pass++) begin
                        if (fin < len || fin - len < floor_a) break;
                        start = fin - len;
                        hitslot = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (hitslot < 0 && rlength[i] != 0 &&
                                start < rstart[i] + 39'(rlength[i]) && fin > rstart[i])
                                hitslot = i;
                        if (hitslot >= 0) begin
                            fin = 39'(rstart[hitslot]);
                        end else begin
                            rstart[s] = start[37:0]; rlength[s] = len[37:0];
                            rflen[s] = i_length; rfoff[s] = i_file_offset;
                            rprot[s] = i_prot; rshared[s] = i_shared;
                            rfile[s] = i_file_id;
                            r.addr = start[37:0]; r.slot = 4'(s);
                            ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            mrt_pkg::REQ_UNMAP: begin
                a = 39'(i_addr);
                if (i_length != 0 && a % PAGE == 0) begin
                    len = round_to_page(39'(i_length));
                    fin = a + len;
                    s = region_holding(a);
                    if (s >= 0) begin
                        rend = rstart[s] + 39'(rlength[s]);
                        if (!(fin > rend || (a != rstart[s] && fin != rend))) begin
                            ok = 1'b1;
                            r.slot = 4'(s); r.file = rfile[s];
                            if (a == rstart[s] && fin == rend) begin
                                drop_slot(s);
                                r.freed = 1'b1;
                            end else if (a == rstart[s]) begin
                                rstart[s] = fin[37:0];
                                rfoff[s] = rfoff[s] + len[31:0];
                                rlength[s] = rlength[s] - len[37:0];
                                rflen[s] = (39'(rflen[s]) > len) ? rflen[s] - len[37:0] : '0;
                            end else begin
                                rlength[s] = rlength[s] - len[37:0];
                                if (rflen[s] > rlength[s]) rflen[s] = rlength[s];
                            end
                        end
                    end
                end
            end
            mrt_pkg::REQ_FAULT: begin
                page = 39'(i_addr) - 39'(i_addr) % PAGE;
                s = region_holding(page);
                if (s >= 0 && !((i_cause == mrt_pkg::CAUSE_LOAD && !rprot[s][0]) ||
                                (i_cause == mrt_pkg::CAUSE_STORE && !rprot[s][1]) ||
                                (i_cause == mrt_pkg::CAUSE_EXEC && !rprot[s][2]))) begin
                    ok = 1'b1;
                    perm = 5'd16;
                    if (rprot[s][0]) perm |= 5'd2;
                    if (rprot[s][1]) perm |= 5'd6;
                    if (rprot[s][2]) perm |= 5'd8;
                    delta = page - rstart[s];
                    rl = '0;
                    if (delta < rflen[s]) begin
                        rl = rflen[s] - delta;
                        if (rl > PAGE) rl = PAGE;
                    end
                    r.slot = 4'(s); r.perm = perm; r.file = rfile[s];
                    r.roff = rfoff[s] + delta[31:0]; r.rlen = rl[12:0];
                end
            end
            mrt_pkg::REQ_QUERY: begin
                ok = 1'b1;
                r.addr = ceiling;
                for (int i = 0; i < NSLOT; i++)
                    if (rlength[i] != 0 && rstart[i] < r.addr) r.addr = rstart[i];
            end
            mrt_pkg::REQ_CLEAR: begin
                ok = 1'b1;
                for (int i = 0; i < NSLOT; i++) drop_slot(i);
            end
            default: ok = 1'b0;
        endcase
        if (!ok) begin
            r = '0;
            r.status = 1'b1;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        o_errors++;
    endtask

    assign o_pending = expected_results.size();

    // Sample at the clock edge: predict accepted requests, check accepted results.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            ceiling = mrt_pkg::CEILING_RESET;
            for (int i = 0; i < NSLOT; i++) drop_slot(i);
            expected_results.delete();
        end else begin
            if (i_cfg_we) ceiling = i_cfg_data;
            if (i_rsp_valid && i_rsp_ready) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status) report_mismatch("status", i_status, want.status);
                    if (i_result_addr !== want.addr)
                        report_mismatch("result_addr", i_result_addr, want.addr);
                    if (i_slot !== want.slot) report_mismatch("slot", i_slot, want.slot);
                    if (i_pte_perm !== want.perm) report_mismatch("pte_perm", i_pte_perm, want.perm);
                    if (i_region_file !== want.file)
                        report_mismatch("region_file", i_region_file, want.file);
                    if (i_read_offset !== want.roff)
                        report_mismatch("read_offset", i_read_offset, want.roff);
                    if (i_read_length !== want.rlen)
                        report_mismatch("read_length", i_read_length, want.rlen);
                    if (i_region_freed !== want.freed)
                        report_mismatch("region_freed", i_region_freed, want.freed);
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(want);
                expected_results.push_back(want);
            end
        end
    end

    initial begin
        o_errors = 0;
        o_results = 0;
    end

endmodule

// ===== dv/mapped_region_table_tb.sv =====
// ----------------------------------------------------------------------------
// Mapped region table testbench
// Drives directed and random map, unmap, fault, query and clear requests with
// random gaps and stalls, across several ceilings; a checker predicts results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mapped_region_table_tb;

    localparam int N_RANDOM = 1750;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [37:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  req_type = '0;
    logic [37:0] req_addr = '0;
    logic [37:0] req_length = '0;
    logic [31:0] req_foff = '0;
    logic [2:0]  req_prot = '0;
    logic        req_shared = 1'b0;
    logic [7:0]  req_file = '0;
    logic [37:0] req_heap = '0;
    logic [3:0]  req_cause = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic        status, freed;
    logic [37:0] result_addr;
    logic [3:0]  slot;
    logic [4:0]  perm;
    logic [7:0]  rfile;
    logic [31:0] roff;
    logic [12:0] rlen;
    int          errors, pending, results;
    int          hold_off = 0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    logic        stimulus_done = 1'b0;

    // Guessed region starts below the ceiling, reused to aim at mapped regions.
    logic [37:0] mapped_starts[$];
    logic [37:0] ceil_now = mrt_pkg::CEILING_RESET;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mapped_region_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready), .i_req_type(req_type),
        .i_addr(req_addr), .i_length(req_length), .i_file_offset(req_foff),
        .i_prot(req_prot), .i_shared(req_shared), .i_file_id(req_file),
        .i_heap_top(req_heap), .i_cause(req_cause), .o_valid(rsp_valid),
        .i_ready(rsp_ready), .o_status(status), .o_result_addr(result_addr),
        .o_slot(slot), .o_pte_perm(perm), .o_region_file(rfile),
        .o_read_offset(roff), .o_read_length(rlen), .o_region_freed(freed)
    );

    mapped_region_table_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_req_valid(req_valid), .i_req_ready(req_ready), .i_req_type(req_type),
        .i_addr(req_addr), .i_length(req_length), .i_file_offset(req_foff),
        .i_prot(req_prot), .i_shared(req_shared), .i_file_id(req_file),
        .i_heap_top(req_heap), .i_cause(req_cause), .i_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready), .i_status(status), .i_result_addr(result_addr),
        .i_slot(slot), .i_pte_perm(perm), .i_region_file(rfile),
        .i_read_offset(roff), .i_read_length(rlen), .i_region_freed(freed),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    function automatic int gap_cycles();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [37:0] rand_wide();
        return 38'({$urandom(), $urandom()});
    endfunction

    // Present one request and hold it until the block takes it. Valid drops
    // for at least one cycle between requests.
    task automatic send_request(logic [2:0] kind, logic [37:0] a, logic [37:0] len,
                                logic [31:0] foff, logic [2:0] prot, logic sh,
                                logic [7:0] fid, logic [37:0] heap, logic [3:0] cause);
        int gap;
        gap = gap_cycles();
        repeat (gap + 1) @(posedge i_clk);
        req_valid <= 1'b1;
        req_type <= kind; req_addr <= a; req_length <= len; req_foff <= foff;
        req_prot <= prot; req_shared <= sh; req_file <= fid; req_heap <= heap;
        req_cause <= cause;
        do @(posedge i_clk); while (!req_ready);
        req_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ceiling(logic [37:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        ceil_now = value;
    endtask

    // One random request, biased toward well-formed maps, unmaps and faults.
    task automatic random_request();
        int pick;
        logic [37:0] a, len, base;
        pick = $urandom_range(0, 99);
        base = mapped_starts.size() ? mapped_starts[$urandom_range(0, mapped_starts.size() - 1)]
                                    : rand_wide();
        len = ($urandom_range(0, 9) == 0) ? rand_wide()
                                          : 38'($urandom_range(1, 6 * 4096));
        if (pick < 38) begin
            send_request(mrt_pkg::REQ_MAP, rand_wide(), len, $urandom(), 3'($urandom()),
                         1'($urandom()), 8'($urandom()),
                         ($urandom_range(0, 3) == 0) ? rand_wide()
                                                     : 38'($urandom_range(0, 1 << 20)),
                         4'($urandom()));
            a = ceil_now - (ceil_now % 4096) - 38'(4096 * $urandom_range(1, 40));
            mapped_starts.push_back(a);
            if (mapped_starts.size() > 32) void'(mapped_starts.pop_front());
        end else if (pick < 65) begin
            a = base - (base % 4096) + 38'(4096 * $urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) a = rand_wide();
            send_request(mrt_pkg::REQ_UNMAP, a, 38'(4096 * $urandom_range(1, 3)) -
                         38'($urandom_range(0, 1) * $urandom_range(0, 4095)),
                         $urandom(), 3'($urandom()), 1'($urandom()), 8'($urandom()),
                         rand_wide(), 4'($urandom()));
        end else if (pick < 90) begin
            a = base + 38'($urandom_range(0, 5 * 4096));
            if ($urandom_range(0, 7) == 0) a = rand_wide();
            send_request(mrt_pkg::REQ_FAULT, a, rand_wide(), $urandom(), 3'($urandom()),
                         1'($urandom()), 8'($urandom()), rand_wide(),
                         ($urandom_range(0, 3) == 0) ? 4'($urandom())
                                                     : 4'(12 + $urandom_range(0, 3)));
        end else if (pick < 96) begin
            send_request(mrt_pkg::REQ_QUERY, rand_wide(), rand_wide(), $urandom(),
                         3'($urandom()), 1'($urandom()), 8'($urandom()), rand_wide(),
                         4'($urandom()));
        end else if (pick < 98) begin
            send_request(mrt_pkg::REQ_CLEAR, rand_wide(), rand_wide(), $urandom(),
                         3'($urandom()), 1'($urandom()), 8'($urandom()), rand_wide(),
                         4'($urandom()));
        end else begin
            send_request(3'($urandom_range(5, 7)), rand_wide(), rand_wide(), $urandom(),
                         3'($urandom()), 1'($urandom()), 8'($urandom()), rand_wide(),
                         4'($urandom()));
        end
    endtask

    // Result side: random stalls, plus a long hold-off when the stimulus asks.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_off <= 400;
            rsp_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
        end else if (stimulus_done) begin
            rsp_ready <= 1'b1;
        end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0) ||
                         ($urandom_range(0, 30) == 0 ? 1'b0 : 1'b1);
            if ($urandom_range(0, 150) == 0) hold_off <= $urandom_range(5, 60);
        end
    end

    initial begin
        logic [37:0] top;
        top = 38'h3F_FFFF_F000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every request kind and the documented corner cases.
        send_request(mrt_pkg::REQ_QUERY, '0, '0, '0, '0, 1'b0, '0, '0, '0);
        send_request(mrt_pkg::REQ_MAP, '0, '0, '0, 3'd7, 1'b1, 8'hFF, '0, '0);
        send_request(mrt_pkg::REQ_MAP, '0, '1, '0, 3'd7, 1'b1, 8'hFF, '0, '0);
        send_request(mrt_pkg::REQ_MAP, '1, 38'd1, 32'hFFFF_FFFF, 3'd1, 1'b0, 8'h01, '0,
                     4'hF);
        send_request(mrt_pkg::REQ_MAP, '0, 38'd9000, 32'hFFFF_F000, 3'd7, 1'b1, 8'h80,
                     38'd5000, '0);
        send_request(mrt_pkg::REQ_MAP, '0, 38'd4096, 32'd0, 3'd4, 1'b0, 8'h02, '1, '0);
        send_request(mrt_pkg::REQ_QUERY, '1, '1, '1, '1, 1'b1, '1, '1, '1);
        send_request(mrt_pkg::REQ_FAULT, mrt_pkg::CEILING_RESET - 38'd1, '0, '0, '0, 1'b0,
                     '0, '0, mrt_pkg::CAUSE_LOAD);
        send_request(mrt_pkg::REQ_FAULT, mrt_pkg::CEILING_RESET - 38'd4096, '0, '0, '0,
                     1'b0, '0, '0, mrt_pkg::CAUSE_STORE);
        send_request(mrt_pkg::REQ_FAULT, mrt_pkg::CEILING_RESET - 38'd12288, '0, '0, '0,
                     1'b0, '0, '0, mrt_pkg::CAUSE_EXEC);
        send_request(mrt_pkg::REQ_FAULT, mrt_pkg::CEILING_RESET - 38'd20480 + 38'd5, '0,
                     '0, '0, 1'b0, '0, '0, mrt_pkg::CAUSE_STORE);
        send_request(mrt_pkg::REQ_FAULT, mrt_pkg::CEILING_RESET - 38'd20480, '0, '0, '0,
                     1'b0, '0, '0, 4'd3);
        send_request(mrt_pkg::REQ_FAULT, '0, '0, '0, '0, 1'b0, '0, '0, mrt_pkg::CAUSE_LOAD);
        send_request(mrt_pkg::REQ_UNMAP, mrt_pkg::CEILING_RESET - 38'd12288, 38'd4096, '0,
                     '0, 1'b0, '0, '0, '0);
        send_request(mrt_pkg::REQ_UNMAP, mrt_pkg::CEILING_RESET - 38'd4096, 38'd4096, '0,
                     '0, 1'b0, '0, '0, '0);
        send_request(mrt_pkg::REQ_UNMAP, mrt_pkg::CEILING_RESET - 38'd20480, 38'd100, '0,
                     '0, 1'b0, '0, '0, '0);
        send_request(mrt_pkg::REQ_UNMAP, mrt_pkg::CEILING_RESET - 38'd16383, 38'd4096, '0,
                     '0, 1'b0, '0, '0, '0);
        send_request(mrt_pkg::REQ_UNMAP, mrt_pkg::CEILING_RESET - 38'd16384, '0, '0, '0,
                     1'b0, '0, '0, '0);
        send_request(mrt_pkg::REQ_UNMAP, mrt_pkg::CEILING_RESET - 38'd16384, 38'd8192, '0,
                     '0, 1'b0, '0, '0, '0);
        send_request(3'd5, '1, '1, '1, '1, 1'b1, '1, '1, '1);
        send_request(3'd7, '0, '0, '0, '0, 1'b0, '0, '0, '0);
        for (int i = 0; i < 18; i++)
            send_request(mrt_pkg::REQ_MAP, '0, 38'd4096, 32'(i), 3'd3, 1'b0, 8'(i), '0, '0);
        send_request(mrt_pkg::REQ_CLEAR, '0, '0, '0, '0, 1'b0, '0, '0, '0);

        // Random phases across several ceilings, including both extremes.
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: write_ceiling('0);
                1: write_ceiling('1);
                2: write_ceiling(38'd65536);
                3: write_ceiling(top - 38'd123);
                4: write_ceiling(rand_wide());
                default: write_ceiling(mrt_pkg::CEILING_RESET);
            endcase
            for (int n = 0; n < N_RANDOM / 7; n++) begin
                if (n == 40) hold_asks++;
                random_request();
            end
            // Sender pauses until every result is back.
            while (pending != 0) @(posedge i_clk);
        end

        wait_drained();
        stimulus_done = 1'b1;
        $display("Covered %0d results over map, unmap, fault, query, clear and bad requests,",
                 results);
        $display("with seven ceiling settings and random stalls on both channels.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #50ms;
        $display("Timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mrt_pkg.sv
rtl/core/mrt_ctrl.sv
rtl/core/mrt_dp.sv
rtl/core/mapped_region_table.sv
dv/mapped_region_table_checker.sv
dv/mapped_region_table_tb.sv
